// File: hdl/cfws_pkg.sv
// Shared types and codes for the circular FIFO with search.
// Holds the request and result payloads and the decoded operation codes.
// No dependencies.
package cfws_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;
  localparam int MODE_W = 3;

  localparam logic [MODE_W-1:0] MODE_ENQ    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd4;

  typedef enum logic [2:0] {
    OP_ENQ,
    OP_DEQ,
    OP_PEEK,
    OP_CLEAR,
    OP_SEARCH,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] data_in;
  } cfws_in_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] data_out;
    logic                     found;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
    logic                     is_full;
  } cfws_out_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] data;
  } cfws_cmd_t;

  // Command queue head as seen by the back end.
  typedef struct packed {
    logic      valid;
    cfws_cmd_t cmd;
  } cfws_qhead_t;

endpackage

// File: hdl/circular_fifo_with_search_core.sv
// Top level of the circular FIFO with search: the capacity register, the
// request front end and the execution back end.
// Depends on cfws_pkg, cfws_front and cfws_back.
//
//   channel   ports                         handshake
//   request   start, busy, in_req           taken when start is high and busy low
//   result    out_valid, out_res            shown for one cycle, cannot be held off
//   config    cfg_we, cfg_wdata             written when cfg_we is high
//
// A request that finds the back end idle is started in the cycle after it is
// taken; otherwise it waits in the front queue. The back end finishes enqueue,
// clear, unused modes and failed requests in its idle state, a successful
// dequeue or peek in a read state that follows, and a search in a search
// state that visits the entries one by one, as the store has one read port.
// The result appears in the cycle after the back end finishes the request.
// Reset empties the queue and the FIFO and sets the capacity to 64; busy rises
// only while the two-entry front queue is full.
module circular_fifo_with_search_core #(
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  cfws_pkg::cfws_in_t               in_req,
  output logic                             out_valid,
  output cfws_pkg::cfws_out_t              out_res,
  input  logic                             cfg_we,
  input  logic [cfws_pkg::CNT_W-1:0]       cfg_wdata
);

  localparam int CAP_MAX = (DEPTH < 127) ? DEPTH : 127;

  logic [cfws_pkg::CNT_W-1:0] cap_r;
  logic [cfws_pkg::CNT_W-1:0] cap_eff;
  cfws_pkg::cfws_qhead_t      head;
  logic                       pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 7'd64;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // A capacity of zero behaves as one; anything above the store depth is clipped.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = 7'd1;
    end else if (cap_r > cfws_pkg::CNT_W'(CAP_MAX)) begin
      cap_eff = cfws_pkg::CNT_W'(CAP_MAX);
    end else begin
      cap_eff = cap_r;
    end
  end

  cfws_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_req (in_req),
    .head   (head),
    .pop    (pop)
  );

  cfws_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap       (cap_eff),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

// File: hdl/cfws_front.sv
// Front end of the circular FIFO with search: accepts requests, decodes the
// mode and holds them in a two-entry queue for the back end.
// Depends on cfws_pkg.
module cfws_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  cfws_pkg::cfws_in_t     in_req,
  output cfws_pkg::cfws_qhead_t  head,
  input  logic                   pop
);

  cfws_pkg::cfws_cmd_t q_r [2];
  logic                wp_r, wp_nxt;
  logic                rp_r, rp_nxt;
  logic [1:0]          n_r, n_nxt;
  logic                push;
  cfws_pkg::cfws_cmd_t cmd_in;

  always_comb begin
    cmd_in.data = in_req.data_in;
    case (in_req.mode)
      cfws_pkg::MODE_ENQ:    cmd_in.op = cfws_pkg::OP_ENQ;
      cfws_pkg::MODE_DEQ:    cmd_in.op = cfws_pkg::OP_DEQ;
      cfws_pkg::MODE_PEEK:   cmd_in.op = cfws_pkg::OP_PEEK;
      cfws_pkg::MODE_CLEAR:  cmd_in.op = cfws_pkg::OP_CLEAR;
      cfws_pkg::MODE_SEARCH: cmd_in.op = cfws_pkg::OP_SEARCH;
      default:               cmd_in.op = cfws_pkg::OP_NONE;
    endcase
  end

  assign busy       = (n_r == 2'd2);
  assign push       = start && !busy;
  assign head.valid = (n_r != 2'd0);
  assign head.cmd   = q_r[rp_r];

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = pop ? ~rp_r : rp_r;
    n_nxt  = n_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      n_r  <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      n_r  <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cmd_in;
    end
  end

endmodule

// File: hdl/cfws_back.sv
// Back end of the circular FIFO with search: owns the entry store, the ring
// indices and the count, and carries out one queued request at a time.
// Depends on cfws_pkg.
module cfws_back #(
  parameter int DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [cfws_pkg::CNT_W-1:0]      cap,
  input  cfws_pkg::cfws_qhead_t           head,
  output logic                            pop,
  output logic                            out_valid,
  output cfws_pkg::cfws_out_t             out_res
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = ((IDX_W > cfws_pkg::CNT_W) ? IDX_W : cfws_pkg::CNT_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SRCH = 3'b100
  } state_t;

  function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] i,
                                                input logic [cfws_pkg::CNT_W-1:0] c);
    logic [CW-1:0] n;
    begin
      n = CW'(i) + CW'(1);
      step_idx = (n >= CW'(c)) ? '0 : n[IDX_W-1:0];
    end
  endfunction

  logic signed [cfws_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [cfws_pkg::DATA_W-1:0] rd_data_r;

  state_t                             state_r, state_nxt;
  logic [IDX_W-1:0]                   rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]                   wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]                   walk_r, walk_nxt;
  logic [cfws_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [cfws_pkg::CNT_W-1:0]         remain_r, remain_nxt;
  logic signed [cfws_pkg::DATA_W-1:0] key_r, key_nxt;
  logic                               deq_r, deq_nxt;
  logic                               out_valid_r, out_valid_nxt;
  cfws_pkg::cfws_out_t                out_res_r, out_res_nxt;

  logic                               mem_we;
  logic                               rd_en;
  logic [IDX_W-1:0]                   rd_addr;
  logic                               ok;
  logic                               found;
  logic signed [cfws_pkg::DATA_W-1:0] dout;

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    walk_nxt      = walk_r;
    cnt_nxt       = cnt_r;
    remain_nxt    = remain_r;
    key_nxt       = key_r;
    deq_nxt       = deq_r;
    out_valid_nxt = 1'b0;
    pop           = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = rd_idx_r;
    ok            = 1'b0;
    found         = 1'b0;
    dout          = '0;

    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.cmd.op)
            cfws_pkg::OP_ENQ: begin
              out_valid_nxt = 1'b1;
              if (cnt_r < cap) begin
                mem_we     = 1'b1;
                wr_idx_nxt = step_idx(wr_idx_r, cap);
                cnt_nxt    = cnt_r + 1'b1;
                ok         = 1'b1;
              end
            end
            cfws_pkg::OP_DEQ, cfws_pkg::OP_PEEK: begin
              if (cnt_r != '0) begin
                rd_en     = 1'b1;
                deq_nxt   = (head.cmd.op == cfws_pkg::OP_DEQ);
                state_nxt = ST_READ;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            cfws_pkg::OP_CLEAR: begin
              rd_idx_nxt    = '0;
              wr_idx_nxt    = '0;
              cnt_nxt       = '0;
              ok            = 1'b1;
              out_valid_nxt = 1'b1;
            end
            cfws_pkg::OP_SEARCH: begin
              ok = 1'b1;
              if (cnt_r != '0) begin
                rd_en      = 1'b1;
                walk_nxt   = step_idx(rd_idx_r, cap);
                remain_nxt = cnt_r;
                key_nxt    = head.cmd.data;
                state_nxt  = ST_SRCH;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        ok            = 1'b1;
        dout          = rd_data_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        if (deq_r) begin
          rd_idx_nxt = step_idx(rd_idx_r, cap);
          cnt_nxt    = cnt_r - 1'b1;
        end
      end
      ST_SRCH: begin
        ok = 1'b1;
        // The store answers one entry a cycle, walking from the front.
        if (rd_data_r == key_r) begin
          found         = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (remain_r == 7'd1) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = walk_r;
          walk_nxt   = step_idx(walk_r, cap);
          remain_nxt = remain_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_res_nxt.ok       = ok;
    out_res_nxt.data_out = dout;
    out_res_nxt.found    = found;
    out_res_nxt.count    = cnt_nxt;
    out_res_nxt.is_empty = (cnt_nxt == '0);
    out_res_nxt.is_full  = (cnt_nxt >= cap);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r    <= walk_nxt;
    remain_r  <= remain_nxt;
    key_r     <= key_nxt;
    deq_r     <= deq_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx_r] <= head.cmd.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
